// ----- rtl/ffba_pkg.sv -----
// Package for the first-fit block allocator: payload structs and fixed codes.
// No dependencies; used by first_fit_block_allocator.
package ffba_pkg;

   localparam int FIELD_W = 11;
   localparam int OWNER_W = 10;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [FIELD_W-1:0] UNIT_COUNT_RESET = 11'd1024;
   localparam logic [FIELD_W-1:0] NO_FIT           = 11'h7FF;

   typedef struct packed {
      logic               func;
      logic [FIELD_W-1:0] request_size;
      logic [OWNER_W-1:0] owner_id;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] start_index;
      logic        [FIELD_W-1:0] freed_count;
   } rsp_type;

endpackage

// ----- rtl/first_fit_block_allocator.sv -----
// First-fit contiguous allocator over a pool of NUM_UNITS units with owner tags.
// Depends on ffba_pkg for payload structs and codes.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | ffba_pkg::req_type (func, size, owner)
//  rsp     | out       | rsp_valid/rsp_ready  | ffba_pkg::rsp_type (start, freed count)
//  csr     | in        | csr_valid/csr_ready  | unit_count, 11 bits
//
// One unit table (used bit + tag) in a single-port-write, one-read memory, swept one
// entry per cycle by a shared compare unit up to min(unit_count, NUM_UNITS); a successful
// allocate stops at the last unit of its run and then fills the run; an empty pool or a
// zero-size allocate skips the sweep and goes straight to the result.
// After reset and after every csr transfer a clearing pass over all NUM_UNITS units runs;
// req_ready stays low meanwhile and csr_ready is low while a request is in progress.
// A stalled rsp holds the next result in its own state.
module first_fit_block_allocator #(
   parameter int NUM_UNITS      = 1024,
   parameter int OWNER_ID_WIDTH = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ffba_pkg::req_type              req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ffba_pkg::rsp_type              rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ffba_pkg::FIELD_W-1:0]   csr_data
);

   localparam int IDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
   localparam int CNT_W = $clog2(NUM_UNITS + 1);
   localparam int ENT_W = OWNER_ID_WIDTH + 1;
   localparam int FW    = ffba_pkg::FIELD_W;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_FILL, S_DONE} state_type;

   state_type                 state_ff, state_in;
   logic [FW-1:0]             unit_count_ff, unit_count_in;
   logic [CNT_W-1:0]          iss_ff, iss_in;
   logic                      chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]          chk_idx_ff;
   logic                      func_ff, func_in;
   logic [FW-1:0]             size_ff, size_in;
   logic [OWNER_ID_WIDTH-1:0] tag_ff, tag_in;
   logic [FW-1:0]             run_ff, run_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          fill_ff, fill_in;
   logic [IDX_W-1:0]          end_ff, end_in;
   logic [FW-1:0]             res_start_ff, res_start_in;
   logic [FW-1:0]             res_freed_ff, res_freed_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ffba_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   logic [ENT_W-1:0]          mem [NUM_UNITS];
   logic [ENT_W-1:0]          rd_data_ff;
   logic [IDX_W-1:0]          rd_addr;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [ENT_W-1:0]          wr_data;

   logic [CNT_W-1:0]          act_n;
   logic [31:0]               owner_ext;
   logic [31:0]               start_calc;
   logic                      issue;
   logic                      chk_last;
   logic                      ent_used;
   logic                      tag_hit;
   logic                      fit;

   function automatic logic [31:0] start_calc_hold(input logic [IDX_W-1:0] last_idx,
                                                   input logic [FW-1:0]    run_len);
      start_calc_hold = 32'(last_idx) + 32'd1 - 32'(run_len);
   endfunction

   assign act_n = (32'(unit_count_ff) > 32'(NUM_UNITS)) ? CNT_W'(NUM_UNITS)
                                                         : CNT_W'(unit_count_ff);
   assign owner_ext  = 32'(req_payload.owner_id);
   assign rd_addr    = iss_ff[IDX_W-1:0];
   assign issue      = (32'(iss_ff) < 32'(act_n));
   assign chk_last   = ((32'(chk_idx_ff) + 32'd1) == 32'(act_n));
   assign ent_used   = rd_data_ff[OWNER_ID_WIDTH];
   assign tag_hit    = (rd_data_ff[OWNER_ID_WIDTH-1:0] == tag_ff);
   assign fit        = !ent_used && ((run_ff + FW'(1)) == size_ff);
   assign start_calc = 32'(chk_idx_ff) + 32'd1 - 32'(size_ff);

   assign req_ready   = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready   = (state_ff == S_IDLE) || (state_ff == S_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      unit_count_in = unit_count_ff;
      iss_in        = iss_ff;
      chk_valid_in  = 1'b0;
      func_in       = func_ff;
      size_in       = size_ff;
      tag_in        = tag_ff;
      run_in        = run_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      end_in        = end_ff;
      res_start_in  = res_start_ff;
      res_freed_in  = res_freed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = rd_addr;
      wr_data       = '0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            iss_in = iss_ff + CNT_W'(1);
            if (32'(iss_ff) == 32'(NUM_UNITS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               func_in  = req_payload.func;
               size_in  = req_payload.request_size;
               tag_in   = owner_ext[OWNER_ID_WIDTH-1:0];
               run_in   = '0;
               count_in = '0;
               iss_in   = '0;
               if (act_n == '0 ||
                   (req_payload.func == ffba_pkg::FUNC_ALLOC &&
                    req_payload.request_size == '0)) begin
                  res_start_in = (req_payload.func == ffba_pkg::FUNC_ALLOC) ?
                                 ffba_pkg::NO_FIT : '0;
                  res_freed_in = '0;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               iss_in       = iss_ff + CNT_W'(1);
               chk_valid_in = 1'b1;
            end
            if (chk_valid_ff) begin
               if (func_ff == ffba_pkg::FUNC_ALLOC) begin
                  run_in = ent_used ? '0 : run_ff + FW'(1);
                  if (fit) begin
                     fill_in      = start_calc[IDX_W-1:0];
                     end_in       = chk_idx_ff;
                     chk_valid_in = 1'b0;
                     state_in     = S_FILL;
                  end else if (chk_last) begin
                     res_start_in = ffba_pkg::NO_FIT;
                     res_freed_in = '0;
                     chk_valid_in = 1'b0;
                     state_in     = S_DONE;
                  end
               end else begin
                  if (ent_used && tag_hit) begin
                     wr_en    = 1'b1;
                     wr_addr  = chk_idx_ff;
                     count_in = count_ff + CNT_W'(1);
                  end
                  if (chk_last) begin
                     res_start_in = '0;
                     res_freed_in = FW'(32'(count_in));
                     chk_valid_in = 1'b0;
                     state_in     = S_DONE;
                  end
               end
            end
         end
         S_FILL: begin
            wr_en   = 1'b1;
            wr_addr = fill_ff;
            wr_data = {1'b1, tag_ff};
            fill_in = fill_ff + IDX_W'(1);
            if (fill_ff == end_ff) begin
               res_start_in = FW'(32'(start_calc_hold(end_ff, size_ff)));
               res_freed_in = '0;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.start_index = res_start_ff;
               rsp_data_in.freed_count = res_freed_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         unit_count_in = csr_data;
         iss_in        = '0;
         chk_valid_in  = 1'b0;
         state_in      = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         unit_count_ff <= ffba_pkg::UNIT_COUNT_RESET;
         iss_ff        <= '0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         unit_count_ff <= unit_count_in;
         iss_ff        <= iss_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      chk_idx_ff   <= rd_addr;
      func_ff      <= func_in;
      size_ff      <= size_in;
      tag_ff       <= tag_in;
      run_ff       <= run_in;
      count_ff     <= count_in;
      fill_ff      <= fill_in;
      end_ff       <= end_in;
      res_start_ff <= res_start_in;
      res_freed_ff <= res_freed_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("accepting requests before the clearing pass");

   a_check_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> state_ff == S_SCAN)
      else $error("table check outside scan");

   a_run_below_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && func_ff == ffba_pkg::FUNC_ALLOC) |-> run_ff < size_ff)
      else $error("free run reached request size without fill");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> fill_ff <= end_ff)
      else $error("fill pointer passed end of run");

   a_one_result_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.start_index == '0 || rsp_data_ff.freed_count == '0))
      else $error("both result fields nonzero");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_block_allocator: directed and random requests,
// predicted by a pool mirror class and checked in order. Depends on ffba_pkg and the RTL.
module testbench;

   localparam int POOL_UNITS = 1024;
   localparam int HOLD_CYCLES = 3000;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ffba_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   ffba_pkg::rsp_type rsp_payload;
   logic              csr_valid;
   logic              csr_ready;
   logic [ffba_pkg::FIELD_W-1:0] csr_data;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_requested = 1'b0;
   bit [ffba_pkg::OWNER_W-1:0] owner_pool [6];

   class pool_mirror;
      bit [ffba_pkg::FIELD_W-1:0] unit_count;
      bit                         unit_used [POOL_UNITS];
      bit [ffba_pkg::OWNER_W-1:0] unit_owner [POOL_UNITS];
      ffba_pkg::rsp_type          pending_replies [$];
      int                         mismatches;

      function new();
         mismatches = 0;
         load_unit_count(ffba_pkg::UNIT_COUNT_RESET);
      endfunction

      function void load_unit_count(bit [ffba_pkg::FIELD_W-1:0] value);
         unit_count = value;
         foreach (unit_used[i]) begin
            unit_used[i]  = 1'b0;
            unit_owner[i] = '0;
         end
      endfunction

      function void accept_request(ffba_pkg::req_type r);
         int                active;
         int                run;
         int                released;
         ffba_pkg::rsp_type reply;
         active = (unit_count > POOL_UNITS) ? POOL_UNITS : int'(unit_count);
         reply.start_index = '0;
         reply.freed_count = '0;
         if (r.func == ffba_pkg::FUNC_ALLOC) begin
            reply.start_index = ffba_pkg::NO_FIT;
            run = 0;
            if (r.request_size != 0) begin
               for (int i = 0; i < active; i++) begin
                  if (unit_used[i]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == r.request_size) begin
                        for (int k = i + 1 - run; k <= i; k++) begin
                           unit_used[k]  = 1'b1;
                           unit_owner[k] = r.owner_id;
                        end
                        reply.start_index = ffba_pkg::FIELD_W'(i + 1 - run);
                        break;
                     end
                  end
               end
            end
         end else begin
            released = 0;
            for (int i = 0; i < active; i++) begin
               if (unit_used[i] && unit_owner[i] == r.owner_id) begin
                  unit_used[i]  = 1'b0;
                  unit_owner[i] = '0;
                  released++;
               end
            end
            reply.freed_count = ffba_pkg::FIELD_W'(released);
         end
         pending_replies.push_back(reply);
      endfunction

      function void check_reply(ffba_pkg::rsp_type got);
         ffba_pkg::rsp_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply, start_index %0d freed_count %0d",
                     $time, got.start_index, got.freed_count);
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.start_index !== want.start_index) begin
            $display("%0t: start_index expected %0d actual %0d",
                     $time, want.start_index, got.start_index);
            mismatches++;
         end
         if (got.freed_count !== want.freed_count) begin
            $display("%0t: freed_count expected %0d actual %0d",
                     $time, want.freed_count, got.freed_count);
            mismatches++;
         end
      endfunction
   endclass

   pool_mirror board;

   first_fit_block_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_reply(rsp_payload);
      end
   end

   initial begin : rsp_side
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requested && !hold_done) begin
            // hold off long enough for the block to fill and stall its input
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
            hold_done = 1'b1;
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      #60_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_item(ffba_pkg::req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      board.accept_request(item);
   endtask

   task automatic issue(logic func, int size, int owner);
      ffba_pkg::req_type r;
      r.func         = func;
      r.request_size = ffba_pkg::FIELD_W'(size);
      r.owner_id     = ffba_pkg::OWNER_W'(owner);
      send_item(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_unit_count(int value);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= ffba_pkg::FIELD_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.load_unit_count(ffba_pkg::FIELD_W'(value));
   endtask

   function automatic ffba_pkg::req_type random_request(int active);
      ffba_pkg::req_type r;
      int                pick;
      r.func = ($urandom_range(99) < 30) ? ffba_pkg::FUNC_FREE : ffba_pkg::FUNC_ALLOC;
      r.owner_id = ($urandom_range(9) == 0) ? ffba_pkg::OWNER_W'($urandom_range(1023))
                                            : owner_pool[$urandom_range(5)];
      pick = $urandom_range(99);
      if (pick < 4) begin
         r.request_size = '0;
      end else if (pick < 8) begin
         r.request_size = ffba_pkg::FIELD_W'($urandom_range(2047));
      end else if (pick < 14) begin
         r.request_size = ffba_pkg::FIELD_W'(active + $urandom_range(3));
      end else begin
         r.request_size = ffba_pkg::FIELD_W'($urandom_range(1,
                                             (active / 4 > 1) ? active / 4 : 1));
      end
      return r;
   endfunction

   task automatic run_random(int units, int count);
      int active;
      active = (units > POOL_UNITS) ? POOL_UNITS : units;
      foreach (owner_pool[i]) owner_pool[i] = ffba_pkg::OWNER_W'($urandom_range(1023));
      repeat (count) send_item(random_request(active));
   endtask

   initial begin
      int units;
      board = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_data    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // full pool straight out of reset
      issue(ffba_pkg::FUNC_ALLOC, 1024, 5);
      issue(ffba_pkg::FUNC_ALLOC, 1, 6);
      issue(ffba_pkg::FUNC_FREE, 0, 5);
      issue(ffba_pkg::FUNC_ALLOC, 0, 9);
      issue(ffba_pkg::FUNC_ALLOC, 2047, 9);
      issue(ffba_pkg::FUNC_ALLOC, 1025, 9);
      issue(ffba_pkg::FUNC_ALLOC, 1, 1023);
      issue(ffba_pkg::FUNC_ALLOC, 3, 0);
      issue(ffba_pkg::FUNC_ALLOC, 2, 1023);
      issue(ffba_pkg::FUNC_FREE, 0, 0);
      issue(ffba_pkg::FUNC_ALLOC, 4, 77);
      issue(ffba_pkg::FUNC_ALLOC, 3, 78);
      issue(ffba_pkg::FUNC_FREE, 0, 1023);
      issue(ffba_pkg::FUNC_FREE, 2047, 555);
      // empty pool
      write_unit_count(0);
      issue(ffba_pkg::FUNC_ALLOC, 1, 3);
      issue(ffba_pkg::FUNC_FREE, 0, 0);
      write_unit_count(1);
      issue(ffba_pkg::FUNC_ALLOC, 1, 1023);
      issue(ffba_pkg::FUNC_ALLOC, 1, 2);
      issue(ffba_pkg::FUNC_FREE, 0, 1023);
      // count above the pool size
      write_unit_count(2047);
      issue(ffba_pkg::FUNC_ALLOC, 1024, 1);
      issue(ffba_pkg::FUNC_FREE, 0, 1);
      // shrink after use: units past the new count are cleared
      write_unit_count(8);
      issue(ffba_pkg::FUNC_ALLOC, 8, 4);
      write_unit_count(3);
      issue(ffba_pkg::FUNC_ALLOC, 3, 4);

      for (int mode = 0; mode < 3; mode++) begin
         wait_idle();
         case (mode)
            0: begin
               req_idle_pct = 8;
               rsp_idle_pct = 71;
            end
            1: begin
               req_idle_pct = 71;
               rsp_idle_pct = 8;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int cfg = 0; cfg < 4; cfg++) begin
            case (cfg)
               0:       units = $urandom_range(4, 48);
               1:       units = $urandom_range(1, 16);
               2:       units = $urandom_range(17, 96);
               default: units = (mode == 1) ? 2047 : 1024;
            endcase
            write_unit_count(units);
            if (mode == 2 && cfg == 0) begin
               hold_requested <= 1'b1;
            end
            run_random(units, (cfg == 3) ? 15 : 60);
         end
      end

      wait_idle();
      repeat (2 * POOL_UNITS + 16) @(posedge clock);
      if (board.mismatches == 0 && board.pending_replies.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
